[hw/rtl/mcpf_pkg.sv]
// Package for the multi-channel PWM fader: default sizes, result and command
// codes, and the channel-state write-enable struct.
// No dependencies.
package mcpf_pkg;

    localparam int CHANNELS_DEF  = 8;
    localparam int FRAC_BITS_DEF = 16;
    localparam int MAX_RESULTS   = 8;

    localparam int FADE_W  = 16;
    localparam int LEVEL_W = 8;
    localparam int CHIN_W  = 4;
    localparam int ACT_W   = 4;
    localparam int CHOUT_W = 3;
    localparam int KIND_W  = 2;
    localparam int CNT_W   = 4;

    localparam logic [KIND_W-1:0] KIND_DUTY    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SET_OK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SET_REJ = 2'd2;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_SET  = 1'b1;

    localparam logic [ACT_W-1:0] ACTIVE_RESET = 4'd8;

    typedef struct packed {
        logic set_we;   // start, target and fade time
        logic lvl_we;   // fixed-point and integer level
    } t_bank_we;

endpackage

[hw/rtl/mcpf_div.sv]
// Restoring divider, one quotient bit per cycle, 16-bit divisor.
// Uses mcpf_pkg for the divisor width.
module mcpf_div #(
    parameter int NUM_W = 25
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [NUM_W-1:0]             i_num,
    input  logic [mcpf_pkg::FADE_W-1:0]  i_den,
    output logic                         o_done,
    output logic [NUM_W-1:0]             o_quo
);

    localparam int CW = $clog2(NUM_W + 1);
    localparam int DW = mcpf_pkg::FADE_W;

    logic            r_busy;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_den;
    logic [NUM_W-1:0] r_quo;

    logic [DW:0]     rem_sh;
    logic            ge;
    logic [DW:0]     rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_quo[NUM_W-1]};
        ge      = rem_sh >= {1'b0, r_den};
        rem_sub = rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // numerator bits shift out of the top while quotient bits enter below
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            r_quo <= {r_quo[NUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

[hw/rtl/mcpf_bank.sv]
// Per-channel fade state: start, target, fade time, fixed and integer level.
// One read address, two write groups; uses mcpf_pkg for widths and t_bank_we.
module mcpf_bank #(
    parameter int CHANNELS = mcpf_pkg::CHANNELS_DEF,
    parameter int LVL_W    = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] i_addr,
    input  mcpf_pkg::t_bank_we            i_we,
    input  logic [mcpf_pkg::LEVEL_W-1:0]  i_start,
    input  logic [mcpf_pkg::LEVEL_W-1:0]  i_target,
    input  logic [mcpf_pkg::FADE_W-1:0]   i_fade,
    input  logic [LVL_W-1:0]              i_lvl_fixed,
    input  logic [mcpf_pkg::LEVEL_W-1:0]  i_lvl_int,
    output logic [mcpf_pkg::LEVEL_W-1:0]  o_start,
    output logic [mcpf_pkg::LEVEL_W-1:0]  o_target,
    output logic [mcpf_pkg::FADE_W-1:0]   o_fade,
    output logic [LVL_W-1:0]              o_lvl_fixed,
    output logic [mcpf_pkg::LEVEL_W-1:0]  o_lvl_int
);

    logic [mcpf_pkg::LEVEL_W-1:0] r_start  [CHANNELS];
    logic [mcpf_pkg::LEVEL_W-1:0] r_target [CHANNELS];
    logic [mcpf_pkg::FADE_W-1:0]  r_fade   [CHANNELS];
    logic [LVL_W-1:0]             r_lvl    [CHANNELS];
    logic [mcpf_pkg::LEVEL_W-1:0] r_lint   [CHANNELS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_start[i]  <= '0;
                r_target[i] <= '0;
                r_fade[i]   <= '0;
                r_lvl[i]    <= '0;
                r_lint[i]   <= '0;
            end
        end else begin
            if (i_we.set_we) begin
                r_start[i_addr]  <= i_start;
                r_target[i_addr] <= i_target;
                r_fade[i_addr]   <= i_fade;
            end
            if (i_we.lvl_we) begin
                r_lvl[i_addr]  <= i_lvl_fixed;
                r_lint[i_addr] <= i_lvl_int;
            end
        end
    end

    assign o_start     = r_start[i_addr];
    assign o_target    = r_target[i_addr];
    assign o_fade      = r_fade[i_addr];
    assign o_lvl_fixed = r_lvl[i_addr];
    assign o_lvl_int   = r_lint[i_addr];

endmodule

[hw/rtl/multi_channel_pwm_fader.sv]
// Top level of the multi-channel PWM fader: command sequencer, result staging.
// Depends on mcpf_pkg, mcpf_div and mcpf_bank.
//
//  channel   direction  payload                                    transaction
//  s_axis    in         tuser func; tdata channel, fade_ms, target  tvalid & tready
//  m_axis    out        tuser kind; tdata out_channel, duty; tlast  tvalid & tready
//  cfg       in         i_cfg_data active_channels                 i_cfg_valid & o_cfg_ready
//
// A set command may run a rescale divide. A tick walks the active channels in turn:
// settled channels are skipped, jumping channels go straight to their target, and
// each fading channel steps through the bit-serial divider.
// Reset is synchronous, active low, and clears all channel state at once.
// s_axis is held off while a command is in progress; a stalled m_axis holds the
// sequencer only when a second result is ready behind the one waiting.
module multi_channel_pwm_fader #(
    parameter int CHANNELS  = mcpf_pkg::CHANNELS_DEF,
    parameter int FRAC_BITS = mcpf_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // channel[3:0], fade_ms[19:4], target[27:20]
    input  logic        s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // out_channel[2:0], duty[10:3]
    output logic [1:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data      // active_channels
);

    localparam int LW   = 8 + FRAC_BITS;
    localparam int NW   = FRAC_BITS + 9;
    localparam int IW   = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
    localparam int NCW  = $clog2(CHANNELS + 1);
    localparam int L8   = mcpf_pkg::LEVEL_W;
    localparam int FW   = mcpf_pkg::FADE_W;
    localparam logic [LW-1:0]   EPS = LW'(((64'd7 << FRAC_BITS) + 64'd65535) >> 16);
    localparam logic [LW+1:0]   ONE_M1 = (LW+2)'((64'd1 << FRAC_BITS) - 64'd1);
    localparam logic [LW-1:0]   LVL_MAX = {LW{1'b1}};

    typedef enum logic [3:0] {
        S_IDLE, S_SET_A, S_SET_B, S_SET_DIV, S_TK_CHK, S_TK_DIV, S_TK_RND, S_TK_EMIT, S_FIN
    } t_state;

    // input fields
    logic [mcpf_pkg::CHIN_W-1:0] in_chan;
    logic [FW-1:0]               in_fade;
    logic [L8-1:0]               in_tgt;

    assign in_chan = s_axis_tdata[3:0];
    assign in_fade = s_axis_tdata[19:4];
    assign in_tgt  = s_axis_tdata[27:20];

    t_state                       r_state, n_state;
    logic [mcpf_pkg::ACT_W-1:0]   r_active;
    logic [IW-1:0]                r_idx, n_idx;
    logic [NCW-1:0]               r_n, n_n;
    logic [FW-1:0]                r_fade, n_fade;
    logic [L8-1:0]                r_tgt, n_tgt;
    logic [mcpf_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic                         r_sub, n_sub;
    logic                         r_fall, n_fall;
    logic                         r_eq, n_eq;
    logic [2*L8-1:0]              r_prod, n_prod;
    logic [LW-1:0]                r_cur, n_cur;
    logic [L8-1:0]                r_set, n_set;

    logic                          r_pend_valid, n_pend_valid;
    logic [mcpf_pkg::KIND_W-1:0]   r_pend_kind, n_pend_kind;
    logic [mcpf_pkg::CHOUT_W-1:0]  r_pend_ch, n_pend_ch;
    logic [L8-1:0]                 r_pend_duty, n_pend_duty;

    logic                          r_out_valid, n_out_valid;
    logic [mcpf_pkg::KIND_W-1:0]   r_out_kind, n_out_kind;
    logic [mcpf_pkg::CHOUT_W-1:0]  r_out_ch, n_out_ch;
    logic [L8-1:0]                 r_out_duty, n_out_duty;
    logic                          r_out_last, n_out_last;

    // bank and divider hookup
    mcpf_pkg::t_bank_we bank_we;
    logic [L8-1:0]  bk_start, bk_target, bk_lint, wr_start, wr_lint;
    logic [FW-1:0]  bk_fade, wr_fade;
    logic [LW-1:0]  bk_lvl, wr_lvl;
    logic           div_start, div_done;
    logic [NW-1:0]  div_num, div_quo;
    logic [FW-1:0]  div_den;

    mcpf_bank #(.CHANNELS(CHANNELS), .LVL_W(LW)) u_bank (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_addr      (r_idx),
        .i_we        (bank_we),
        .i_start     (wr_start),
        .i_target    (r_tgt),
        .i_fade      (wr_fade),
        .i_lvl_fixed (wr_lvl),
        .i_lvl_int   (wr_lint),
        .o_start     (bk_start),
        .o_target    (bk_target),
        .o_fade      (bk_fade),
        .o_lvl_fixed (bk_lvl),
        .o_lvl_int   (bk_lint)
    );

    mcpf_div #(.NUM_W(NW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // datapath terms
    logic           out_free;
    logic           set_bad;
    logic [LW-1:0]  tgt_fx, abs_diff;
    logic [LW-1:0]  dest_fx;
    logic signed [L8:0] sd, span;
    logic [L8-1:0]  mag;
    logic [LW-1:0]  quo;
    logic [LW+1:0]  sum;
    logic [LW+1:0]  fall_v;
    logic [9:0]     fall_c;
    logic [L8:0]    rise_c;
    logic [L8-1:0]  set_lvl;
    logic [L8-1:0]  lo, hi;
    logic           hit;
    logic           last_ch;

    always_comb begin
        out_free = !r_out_valid || m_axis_tready;
        set_bad  = (in_chan == '0) || (in_chan > r_active) || (32'(in_chan) > CHANNELS);

        tgt_fx   = {r_tgt, {FRAC_BITS{1'b0}}};
        abs_diff = (bk_lvl > tgt_fx) ? bk_lvl - tgt_fx : tgt_fx - bk_lvl;
        dest_fx  = {bk_target, {FRAC_BITS{1'b0}}};

        sd   = $signed({1'b0, bk_start}) - $signed({1'b0, bk_target});
        span = (bk_lint > bk_target) ? sd : -sd;
        mag  = span[L8] ? L8'(-span) : span[L8-1:0];

        // signed step applied to the current level, then clamp
        quo = div_quo[LW-1:0];
        sum = r_sub ? {2'b00, bk_lvl} - {2'b00, quo} : {2'b00, bk_lvl} + {2'b00, quo};
        if (r_sub && (quo > bk_lvl)) begin
            sum = '0;
        end else if (sum[LW]) begin
            sum = {2'b00, LVL_MAX};
        end

        // falling rounds up, rising rounds down, both with the epsilon
        fall_v = {2'b00, r_cur} - {2'b00, EPS} + ONE_M1;
        fall_c = (r_cur > EPS) ? 10'(fall_v >> FRAC_BITS) : '0;
        if (fall_c > 10'd255) begin
            fall_c = 10'd255;
        end
        rise_c = (L8+1)'(({1'b0, r_cur} + {1'b0, EPS}) >> FRAC_BITS);
        if (r_fall) begin
            set_lvl = (fall_c[L8-1:0] > bk_target) ? fall_c[L8-1:0] : bk_target;
        end else begin
            set_lvl = (rise_c < {1'b0, bk_target}) ? rise_c[L8-1:0] : bk_target;
        end

        lo  = (bk_start < bk_target) ? bk_start : bk_target;
        hi  = (bk_start < bk_target) ? bk_target : bk_start;
        hit = (lo <= r_set) && (r_set <= hi)
              && (r_cnt < mcpf_pkg::CNT_W'(mcpf_pkg::MAX_RESULTS));
        last_ch = (NCW'(r_idx) + NCW'(1)) == r_n;
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_n          = r_n;
        n_fade       = r_fade;
        n_tgt        = r_tgt;
        n_cnt        = r_cnt;
        n_sub        = r_sub;
        n_fall       = r_fall;
        n_eq         = r_eq;
        n_prod       = r_prod;
        n_cur        = r_cur;
        n_set        = r_set;
        n_pend_valid = r_pend_valid;
        n_pend_kind  = r_pend_kind;
        n_pend_ch    = r_pend_ch;
        n_pend_duty  = r_pend_duty;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_kind   = r_out_kind;
        n_out_ch     = r_out_ch;
        n_out_duty   = r_out_duty;
        n_out_last   = r_out_last;

        bank_we   = '0;
        wr_start  = bk_lvl[LW-1:FRAC_BITS];
        wr_fade   = '0;
        wr_lvl    = dest_fx;
        wr_lint   = bk_target;
        div_start = 1'b0;
        div_num   = NW'(mag) << FRAC_BITS;
        div_den   = bk_fade;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_fade = in_fade;
                    n_tgt  = in_tgt;
                    n_cnt  = '0;
                    n_idx  = '0;
                    if (s_axis_tuser == mcpf_pkg::FUNC_SET) begin
                        if (set_bad) begin
                            n_pend_valid = 1'b1;
                            n_pend_kind  = mcpf_pkg::KIND_SET_REJ;
                            n_pend_ch    = '0;
                            n_pend_duty  = '0;
                            n_state      = S_FIN;
                        end else begin
                            n_idx   = IW'(in_chan - 1'b1);
                            n_state = S_SET_A;
                        end
                    end else begin
                        n_n = (32'(r_active) > CHANNELS) ? NCW'(CHANNELS) : NCW'(r_active);
                        n_state = (r_active == '0) ? S_IDLE : S_TK_CHK;
                    end
                end
            end
            S_SET_A: begin
                n_eq    = bk_lvl == dest_fx;
                n_prod  = r_tgt * abs_diff[LW-1:FRAC_BITS];
                n_state = S_SET_B;
            end
            S_SET_B: begin
                if (r_fade == '0 || r_eq) begin
                    bank_we.set_we = 1'b1;
                    wr_fade        = r_eq ? r_fade : '0;
                    n_pend_valid   = 1'b1;
                    n_pend_kind    = mcpf_pkg::KIND_SET_OK;
                    n_pend_ch      = mcpf_pkg::CHOUT_W'(r_idx);
                    n_pend_duty    = '0;
                    n_state        = S_FIN;
                end else begin
                    div_start = 1'b1;
                    div_num   = NW'(r_prod) + NW'(r_fade) - NW'(1);
                    div_den   = r_fade;
                    n_state   = S_SET_DIV;
                end
            end
            S_SET_DIV: begin
                if (div_done) begin
                    bank_we.set_we = 1'b1;
                    wr_fade        = div_quo[FW-1:0];
                    n_pend_valid   = 1'b1;
                    n_pend_kind    = mcpf_pkg::KIND_SET_OK;
                    n_pend_ch      = mcpf_pkg::CHOUT_W'(r_idx);
                    n_pend_duty    = '0;
                    n_state        = S_FIN;
                end
            end
            S_TK_CHK: begin
                if (bk_lint == bk_target) begin
                    if (last_ch) begin
                        n_state = S_FIN;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else if (bk_fade == '0) begin
                    // jump straight to the target
                    bank_we.lvl_we = 1'b1;
                    n_set          = bk_target;
                    n_state        = S_TK_EMIT;
                end else begin
                    n_fall    = bk_lint > bk_target;
                    n_sub     = (bk_lint > bk_target) ^ span[L8];
                    div_start = 1'b1;
                    n_state   = S_TK_DIV;
                end
            end
            S_TK_DIV: begin
                if (div_done) begin
                    n_cur   = sum[LW-1:0];
                    n_state = S_TK_RND;
                end
            end
            S_TK_RND: begin
                bank_we.lvl_we = 1'b1;
                wr_lvl         = (set_lvl == bk_target) ? dest_fx : r_cur;
                wr_lint        = set_lvl;
                n_set          = set_lvl;
                n_state        = S_TK_EMIT;
            end
            S_TK_EMIT: begin
                if (hit && r_pend_valid && !out_free) begin
                    n_state = S_TK_EMIT;
                end else begin
                    if (hit) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_kind  = r_pend_kind;
                            n_out_ch    = r_pend_ch;
                            n_out_duty  = r_pend_duty;
                            n_out_last  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_kind  = mcpf_pkg::KIND_DUTY;
                        n_pend_ch    = mcpf_pkg::CHOUT_W'(r_idx);
                        n_pend_duty  = r_set;
                        n_cnt        = r_cnt + 1'b1;
                    end
                    if (last_ch) begin
                        n_state = S_FIN;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_TK_CHK;
                    end
                end
            end
            S_FIN: begin
                // release the held result as the final one of this command
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = r_pend_kind;
                    n_out_ch     = r_pend_ch;
                    n_out_duty   = r_pend_duty;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_active     <= mcpf_pkg::ACTIVE_RESET;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_cnt        <= '0;
            r_idx        <= '0;
            r_n          <= '0;
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            r_cnt        <= n_cnt;
            r_idx        <= n_idx;
            r_n          <= n_n;
            r_fade       <= n_fade;
            r_tgt        <= n_tgt;
            r_sub        <= n_sub;
            r_fall       <= n_fall;
            r_eq         <= n_eq;
            r_prod       <= n_prod;
            r_cur        <= n_cur;
            r_set        <= n_set;
            r_pend_kind  <= n_pend_kind;
            r_pend_ch    <= n_pend_ch;
            r_pend_duty  <= n_pend_duty;
            r_out_kind   <= n_out_kind;
            r_out_ch     <= n_out_ch;
            r_out_duty   <= n_out_duty;
            r_out_last   <= n_out_last;
            if (i_cfg_valid) begin
                r_active <= i_cfg_data;
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_duty, r_out_ch};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

endmodule

[dv/multi_channel_pwm_fader_tb.sv]
// Self-checking testbench for multi_channel_pwm_fader: tracks channel levels, fade steps
// and set acknowledgements on its own and checks each m_axis transaction against them.
// Depends on mcpf_pkg and the multi_channel_pwm_fader RTL.
module multi_channel_pwm_fader_tb;

    localparam int NCH = mcpf_pkg::CHANNELS_DEF;
    localparam int FRAC = mcpf_pkg::FRAC_BITS_DEF;
    localparam int CHIN_W = mcpf_pkg::CHIN_W;
    localparam int FADE_W = mcpf_pkg::FADE_W;
    localparam int LEVEL_W = mcpf_pkg::LEVEL_W;
    localparam int KIND_W = mcpf_pkg::KIND_W;
    localparam int CHOUT_W = mcpf_pkg::CHOUT_W;
    localparam int ACT_W = mcpf_pkg::ACT_W;
    localparam longint ONE_FX = longint'(1) << FRAC;
    localparam longint EPS_FX = ((longint'(7) << FRAC) + 65535) >>> 16;
    localparam longint LVL_TOP = (longint'(256) << FRAC) - 1;
    localparam int SETTLE_CYCLES = 400;
    localparam int PHASE_ITEMS = 20;

    typedef struct packed {
        logic              func;
        logic [CHIN_W-1:0] channel;
        logic [FADE_W-1:0] fade;
        logic [LEVEL_W-1:0] target;
    } t_fader_cmd;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [CHOUT_W-1:0] ch;
        logic [LEVEL_W-1:0] duty;
        logic               last;
    } t_fader_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_data;

    // own copy of the channel state
    logic [ACT_W-1:0]   act_cnt;
    logic [LEVEL_W-1:0] lvl_start [NCH];
    logic [LEVEL_W-1:0] lvl_goal [NCH];
    logic [FADE_W-1:0]  ramp_ms [NCH];
    longint             lvl_fx [NCH];
    logic [LEVEL_W-1:0] lvl_now [NCH];

    t_fader_out pending_fader_out[$];
    int         errors;
    bit         no_idle;
    int         hold_cycles;

    multi_channel_pwm_fader uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40000000;
        $display("DONE: errors detected");
        $finish;
    end

    // Work out the results of one accepted command and advance the channel state.
    task automatic advance_fader(input t_fader_cmd c);
        t_fader_out r;
        t_fader_out batch[$];
        int idx, n, wait_ms, diff, span, mag, dest, st, setl, lo, hi;
        longint cur, tf, step, v, cval;
        bit falling;
        if (c.func == mcpf_pkg::FUNC_SET) begin
            if (c.channel == 0 || c.channel > act_cnt || c.channel > NCH) begin
                r.kind = mcpf_pkg::KIND_SET_REJ;
                r.ch = '0;
                r.duty = '0;
                r.last = 1'b1;
                pending_fader_out.push_back(r);
            end else begin
                idx = int'(c.channel) - 1;
                cur = lvl_fx[idx];
                wait_ms = 0;
                if (c.fade > 0) begin
                    if (cur == (longint'(lvl_goal[idx]) << FRAC)) begin
                        wait_ms = int'(c.fade);
                    end else begin
                        // caught mid-fade: rescale the fade time by the remaining distance
                        tf = longint'(c.target) << FRAC;
                        diff = (cur > tf) ? int'((cur - tf) >>> FRAC)
                                          : int'((tf - cur) >>> FRAC);
                        wait_ms = (int'(c.target) * diff + int'(c.fade) - 1) / int'(c.fade);
                    end
                end
                lvl_start[idx] = LEVEL_W'(cur >>> FRAC);
                lvl_goal[idx] = c.target;
                ramp_ms[idx] = FADE_W'(wait_ms);
                r.kind = mcpf_pkg::KIND_SET_OK;
                r.ch = CHOUT_W'(idx);
                r.duty = '0;
                r.last = 1'b1;
                pending_fader_out.push_back(r);
            end
        end else begin
            n = (int'(act_cnt) < NCH) ? int'(act_cnt) : NCH;
            for (int i = 0; i < n; i++) begin
                dest = int'(lvl_goal[i]);
                st = int'(lvl_start[i]);
                if (int'(lvl_now[i]) == dest)
                    continue;
                if (ramp_ms[i] == 0) begin
                    setl = dest;
                    lvl_now[i] = LEVEL_W'(dest);
                    lvl_fx[i] = longint'(dest) << FRAC;
                end else begin
                    falling = int'(lvl_now[i]) > dest;
                    span = falling ? st - dest : dest - st;
                    mag = (span < 0) ? -span : span;
                    step = (longint'(mag) << FRAC) / longint'(ramp_ms[i]);
                    if (span < 0)
                        step = -step;
                    cur = falling ? lvl_fx[i] - step : lvl_fx[i] + step;
                    if (cur < 0)
                        cur = 0;
                    if (cur > LVL_TOP)
                        cur = LVL_TOP;
                    // round up on the way down, down on the way up
                    if (falling) begin
                        v = cur - EPS_FX;
                        cval = (v <= 0) ? 0 : ((v + ONE_FX - 1) >>> FRAC);
                        if (cval > 255)
                            cval = 255;
                        setl = (cval > dest) ? int'(cval) : dest;
                    end else begin
                        cval = (cur + EPS_FX) >>> FRAC;
                        setl = (cval < dest) ? int'(cval) : dest;
                    end
                    lvl_fx[i] = cur;
                    lvl_now[i] = LEVEL_W'(setl);
                    if (setl == dest)
                        lvl_fx[i] = longint'(dest) << FRAC;
                end
                lo = (st < dest) ? st : dest;
                hi = (st < dest) ? dest : st;
                if (lo <= setl && setl <= hi && batch.size() < mcpf_pkg::MAX_RESULTS) begin
                    r.kind = mcpf_pkg::KIND_DUTY;
                    r.ch = CHOUT_W'(i);
                    r.duty = LEVEL_W'(setl);
                    r.last = 1'b0;
                    batch.push_back(r);
                end
            end
            if (batch.size() > 0)
                batch[batch.size() - 1].last = 1'b1;
            foreach (batch[k])
                pending_fader_out.push_back(batch[k]);
        end
    endtask

    // Offer one command on s_axis after a random gap (none when no_idle is set); return at the accepting edge.
    task automatic send_cmd(input logic func, input logic [3:0] ch,
                            input logic [15:0] fade, input logic [7:0] tgt);
        t_fader_cmd c;
        int gap;
        c.func = func;
        c.channel = ch;
        c.fade = fade;
        c.target = tgt;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= func;
        s_axis_tdata <= {4'd0, tgt, fade, ch};
        do @(posedge i_clk); while (!s_axis_tready);
        advance_fader(c);
    endtask

    // Drop valid, wait for every owed result, then let a tick with no output finish.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_fader_out.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_active(input logic [3:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        act_cnt = v;
    endtask

    function automatic t_fader_cmd rand_cmd();
        t_fader_cmd c;
        int pick, lim, fsel;
        pick = $urandom_range(0, 99);
        lim = (int'(act_cnt) < NCH) ? int'(act_cnt) : NCH;
        c.func = (pick < 30) ? mcpf_pkg::FUNC_SET : mcpf_pkg::FUNC_TICK;
        c.channel = CHIN_W'($urandom_range(0, 15));
        c.target = LEVEL_W'($urandom_range(0, 255));
        fsel = $urandom_range(0, 9);
        if (fsel == 0)
            c.fade = '0;
        else if (fsel == 1)
            c.fade = FADE_W'($urandom_range(0, 65535));
        else
            c.fade = FADE_W'($urandom_range(1, 24));
        // mostly valid channels, a few out of range
        if (c.func == mcpf_pkg::FUNC_SET && pick >= 4 && lim > 0)
            c.channel = CHIN_W'($urandom_range(1, lim));
        return c;
    endfunction

    task automatic send_random(input int count);
        t_fader_cmd c;
        for (int k = 0; k < count; k++) begin
            c = rand_cmd();
            send_cmd(c.func, c.channel, c.fade, c.target);
        end
    endtask

    task automatic test_directed();
        send_cmd(mcpf_pkg::FUNC_TICK, 4'd0, 16'd0, 8'd0);
        send_cmd(mcpf_pkg::FUNC_SET, 4'd0, 16'd5, 8'd10);
        send_cmd(mcpf_pkg::FUNC_SET, 4'd15, 16'hFFFF, 8'hFF);
        send_cmd(mcpf_pkg::FUNC_SET, 4'd1, 16'd0, 8'd255);
        send_cmd(mcpf_pkg::FUNC_TICK, 4'd15, 16'hFFFF, 8'hFF);
        send_cmd(mcpf_pkg::FUNC_SET, 4'd8, 16'd4, 8'd200);
        send_cmd(mcpf_pkg::FUNC_SET, 4'd1, 16'd3, 8'd0);
        repeat (4) send_cmd(mcpf_pkg::FUNC_TICK, 4'd0, 16'd0, 8'd0);
        send_cmd(mcpf_pkg::FUNC_SET, 4'd2, 16'hFFFF, 8'd128);
        send_cmd(mcpf_pkg::FUNC_TICK, 4'd0, 16'd0, 8'd0);
        // retarget while still fading
        send_cmd(mcpf_pkg::FUNC_SET, 4'd2, 16'd10, 8'd40);
        repeat (4) send_cmd(mcpf_pkg::FUNC_TICK, 4'd0, 16'd0, 8'd0);
        send_cmd(mcpf_pkg::FUNC_SET, 4'd3, 16'd1, 8'd1);
        send_cmd(mcpf_pkg::FUNC_TICK, 4'd0, 16'd0, 8'd0);
        send_cmd(mcpf_pkg::FUNC_SET, 4'd4, 16'd0, 8'd0);
        send_cmd(mcpf_pkg::FUNC_TICK, 4'd0, 16'd0, 8'd0);
        wait_idle();
    endtask

    task automatic test_active_range();
        logic [3:0] settings[5];
        settings = '{4'd1, 4'd0, 4'd15, 4'd5, 4'd8};
        foreach (settings[k]) begin
            write_active(settings[k]);
            send_random(PHASE_ITEMS);
            wait_idle();
        end
    endtask

    task automatic test_output_stall();
        t_fader_cmd c;
        no_idle = 1'b1;
        hold_cycles = 300;
        for (int k = 0; k < 30; k++) begin
            c = rand_cmd();
            if (k % 3 != 2) begin
                c.func = mcpf_pkg::FUNC_SET;
                c.channel = CHIN_W'($urandom_range(1, NCH));
            end
            send_cmd(c.func, c.channel, c.fade, c.target);
        end
        no_idle = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_mix();
        for (int blk = 0; blk < 6; blk++) begin
            no_idle = ($urandom_range(0, 3) == 0);
            send_random(40);
        end
        no_idle = 1'b0;
        wait_idle();
    endtask

    // Receiver: random stall before each transaction (none when no_idle is set), or a long hold when asked.
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 17);
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin
        t_fader_out got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind = m_axis_tuser;
            got.ch = m_axis_tdata[2:0];
            got.duty = m_axis_tdata[10:3];
            got.last = m_axis_tlast;
            if (pending_fader_out.size() == 0) begin
                errors++;
                $display({"%0t: unexpected result: expected none, ",
                          "actual kind %0d ch %0d duty %0d last %0d"},
                         $time, got.kind, got.ch, got.duty, got.last);
            end else begin
                want = pending_fader_out.pop_front();
                if (got != want) begin
                    errors++;
                    $display({"%0t: mismatch: expected kind %0d ch %0d duty %0d last %0d, ",
                              "actual kind %0d ch %0d duty %0d last %0d"},
                             $time, want.kind, want.ch, want.duty, want.last,
                             got.kind, got.ch, got.duty, got.last);
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        errors = 0;
        no_idle = 1'b0;
        hold_cycles = 0;
        act_cnt = mcpf_pkg::ACTIVE_RESET;
        for (int i = 0; i < NCH; i++) begin
            lvl_start[i] = '0;
            lvl_goal[i] = '0;
            ramp_ms[i] = '0;
            lvl_fx[i] = 0;
            lvl_now[i] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_directed();
        test_active_range();
        test_output_stall();
        test_random_mix();

        if (pending_fader_out.size() != 0) begin
            errors += pending_fader_out.size();
            $display("%0t: %0d expected results never arrived", $time,
                     pending_fader_out.size());
        end
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
hw/rtl/mcpf_pkg.sv
hw/rtl/mcpf_div.sv
hw/rtl/mcpf_bank.sv
hw/rtl/multi_channel_pwm_fader.sv
dv/multi_channel_pwm_fader_tb.sv
